@@ rtl/tmps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared sizes and constants for the triangle minimum path sum block.
// ----------------------------------------------------------------------------
package tmps_pkg;

    // Row capacity of the best-sum memory.
    localparam int MAX_ROWS = 256;

    localparam int ELEM_W  = 16;
    localparam int SUM_W   = 32;
    localparam int CFG_W   = 9;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [ROW_W-1:0]         row_t;
    typedef logic [CFG_W-1:0]         cfg_t;
    typedef logic [CMP_W-1:0]         cmp_t;

endpackage : tmps_pkg
`default_nettype wire

@@ rtl/tmps_elem_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_elem_if
// Valid/ready channel that carries one triangle element per word.
// ----------------------------------------------------------------------------
interface tmps_elem_if;
    logic             valid;
    logic             ready;
    tmps_pkg::elem_t  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface : tmps_elem_if
`default_nettype wire

@@ rtl/tmps_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_result_if
// Valid/ready channel that carries the minimum path sum of one triangle.
// ----------------------------------------------------------------------------
interface tmps_result_if;
    logic            valid;
    logic            ready;
    tmps_pkg::sum_t  min_total;
    logic            saturated;

    modport source (output valid, output min_total, output saturated, input ready);
    modport sink   (input valid, input min_total, input saturated, output ready);
endinterface : tmps_result_if
`default_nettype wire

@@ rtl/triangle_min_path_sum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_min_path_sum
// Streaming minimum top-to-bottom path sum of a number triangle.
// ----------------------------------------------------------------------------
// Elements enter on the elem channel, top row first and left to right, one
// word per element. The row_count register (write enable and data, no
// read-back) sets the number of rows; the user must see that it is written
// only while the block is idle, as the block itself does not enforce this.
// One row of best partial sums lives in a synchronous RAM; each element reads
// the entry above it on acceptance, and the sum is formed in the compute
// stage and written back when that stage fires, so one element is accepted
// every cycle while nothing stalls. A read that meets the write of the same
// entry is served from the write data. When the final element of the last
// row leaves the compute stage, the minimum of that row is loaded into the
// output register and appears on the result channel, together with a flag
// that tells whether any partial sum was clamped to 32 bits. The block then
// rearms at once. While the result waits, elements keep flowing; only a
// further final element stalls, and elem.ready then drops. Reset clears the
// counters and control state and sets row_count to one; the RAM needs no
// clearing, since every entry used was written in the same triangle.
// ----------------------------------------------------------------------------
module triangle_min_path_sum
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  row_count_we,
    input  wire logic [8:0]            row_count_wdata,
    tmps_elem_if.sink                  elem,
    tmps_result_if.source              result
);

    // Configuration
    tmps_pkg::cfg_t row_count_reg;
    tmps_pkg::cmp_t eff_rows;

    // Issue stage counters
    tmps_pkg::row_t row_index_reg, row_index_next;
    tmps_pkg::row_t column_index_reg, column_index_next;

    // Compute stage
    logic            s1_valid_reg;
    tmps_pkg::elem_t s1_value_reg;
    tmps_pkg::row_t  s1_col_reg;
    logic            s1_first_row_reg;
    logic            s1_last_col_reg;
    logic            s1_final_reg;
    logic            fwd_hit_reg;
    tmps_pkg::sum_t  fwd_data_reg;
    tmps_pkg::sum_t  rd_data_reg;

    tmps_pkg::sum_t  held_left_sum_reg, held_left_sum_next;
    tmps_pkg::sum_t  running_row_min_reg, running_row_min_next;
    logic            saturation_seen_reg, saturation_seen_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    tmps_pkg::sum_t  out_total_reg;
    logic            out_sat_reg;

    tmps_pkg::sum_t  best_mem [tmps_pkg::MAX_ROWS];

    logic            accept;
    logic            s1_fire;
    logic            out_free;
    logic            last_col;
    logic            last_row;
    logic            fwd_hit;

    tmps_pkg::sum_t  above;
    tmps_pkg::sum_t  pred;
    logic [tmps_pkg::SUM_W:0] sum_wide;
    logic            ovf;
    tmps_pkg::sum_t  sum_sat;
    tmps_pkg::sum_t  new_min;

    // ------------------------------------------------------------------
    // Configuration register and effective row count.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= tmps_pkg::cfg_t'(1);
        end
        else if (row_count_we)
        begin
            row_count_reg <= row_count_wdata;
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            eff_rows = tmps_pkg::cmp_t'(1);
        end
        else if (tmps_pkg::cmp_t'(row_count_reg) > tmps_pkg::cmp_t'(tmps_pkg::MAX_ROWS))
        begin
            eff_rows = tmps_pkg::cmp_t'(tmps_pkg::MAX_ROWS);
        end
        else
        begin
            eff_rows = tmps_pkg::cmp_t'(row_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes.
    // ------------------------------------------------------------------
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && (!s1_final_reg || out_free);
    assign elem.ready = !s1_valid_reg || s1_fire;
    assign accept     = elem.valid && elem.ready;

    // ------------------------------------------------------------------
    // Issue stage: position counters and the RAM read.
    // ------------------------------------------------------------------
    assign last_col = (column_index_reg == row_index_reg);
    assign last_row = (tmps_pkg::cmp_t'(row_index_reg) + tmps_pkg::cmp_t'(1)) >= eff_rows;
    assign fwd_hit  = s1_fire && (s1_col_reg == column_index_reg);

    always_comb
    begin
        row_index_next    = row_index_reg;
        column_index_next = column_index_reg;
        if (accept)
        begin
            if (!last_col)
            begin
                column_index_next = column_index_reg + tmps_pkg::row_t'(1);
            end
            else if (last_row)
            begin
                row_index_next    = '0;
                column_index_next = '0;
            end
            else
            begin
                row_index_next    = row_index_reg + tmps_pkg::row_t'(1);
                column_index_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg    <= '0;
            column_index_reg <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            row_index_reg    <= row_index_next;
            column_index_reg <= column_index_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_value_reg     <= elem.element_value;
            s1_col_reg       <= column_index_reg;
            s1_first_row_reg <= (row_index_reg == '0);
            s1_last_col_reg  <= last_col;
            s1_final_reg     <= last_col && last_row;
            fwd_hit_reg      <= fwd_hit;
            fwd_data_reg     <= sum_sat;
        end
    end

    // Best-sum row RAM: one registered read port, one write port.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= best_mem[column_index_reg];
        end
        if (s1_fire)
        begin
            best_mem[s1_col_reg] <= sum_sat;
        end
    end

    // ------------------------------------------------------------------
    // Compute stage: predecessor, saturating add, row minimum.
    // ------------------------------------------------------------------
    assign above = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        if (s1_first_row_reg)
        begin
            pred = '0;
        end
        else if (s1_last_col_reg)
        begin
            pred = held_left_sum_reg;
        end
        else if (s1_col_reg == '0)
        begin
            pred = above;
        end
        else
        begin
            pred = (held_left_sum_reg < above) ? held_left_sum_reg : above;
        end
    end

    assign sum_wide = {pred[tmps_pkg::SUM_W-1], pred}
                    + (tmps_pkg::SUM_W+1)'(s1_value_reg);
    assign ovf      = sum_wide[tmps_pkg::SUM_W] != sum_wide[tmps_pkg::SUM_W-1];

    always_comb
    begin
        if (!ovf)
        begin
            sum_sat = sum_wide[tmps_pkg::SUM_W-1:0];
        end
        else if (sum_wide[tmps_pkg::SUM_W])
        begin
            sum_sat = tmps_pkg::SUM_MIN;
        end
        else
        begin
            sum_sat = tmps_pkg::SUM_MAX;
        end
    end

    assign new_min = ((s1_col_reg == '0) || (sum_sat < running_row_min_reg))
                   ? sum_sat : running_row_min_reg;

    always_comb
    begin
        held_left_sum_next   = held_left_sum_reg;
        running_row_min_next = running_row_min_reg;
        saturation_seen_next = saturation_seen_reg;
        if (s1_fire)
        begin
            if (s1_final_reg)
            begin
                // Rearm for the next triangle.
                held_left_sum_next   = '0;
                running_row_min_next = tmps_pkg::SUM_MAX;
                saturation_seen_next = 1'b0;
            end
            else
            begin
                if (!s1_first_row_reg && !s1_last_col_reg)
                begin
                    held_left_sum_next = above;
                end
                running_row_min_next = new_min;
                saturation_seen_next = saturation_seen_reg || ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_left_sum_reg   <= '0;
            running_row_min_reg <= tmps_pkg::SUM_MAX;
            saturation_seen_reg <= 1'b0;
        end
        else
        begin
            held_left_sum_reg   <= held_left_sum_next;
            running_row_min_reg <= running_row_min_next;
            saturation_seen_reg <= saturation_seen_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && s1_final_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_final_reg)
        begin
            out_total_reg <= new_min;
            out_sat_reg   <= saturation_seen_reg || ovf;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.min_total = out_total_reg;
    assign result.saturated = out_sat_reg;

endmodule : triangle_min_path_sum
`default_nettype wire

@@ rtl/tmps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmps_checker
// Port-level checks on the triangle minimum path sum block.
// ----------------------------------------------------------------------------
module tmps_checker
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  elem_valid,
    input wire logic                  elem_ready,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire tmps_pkg::sum_t        min_total,
    input wire logic                  saturated
);

    // A waiting result word is neither dropped nor changed.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(min_total) && $stable(saturated))
        else $error("result word changed while stalled");

    // With the output register empty the element side never stalls.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> elem_ready)
        else $error("elements stalled with no result waiting");

    // A new result word always follows an accepted element.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(elem_valid && elem_ready, 2))
        else $error("result word without a matching final element");

endmodule : tmps_checker

bind triangle_min_path_sum tmps_checker u_tmps_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .elem_valid   (elem.valid),
    .elem_ready   (elem.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .min_total    (result.min_total),
    .saturated    (result.saturated)
);
`default_nettype wire
